@@ rtl/selective_repeat_sender_window_top_defines.svh @@
// assertion macros for the selective-repeat sender window block
// used by srsw_core; no other dependencies
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SRSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srsw assertion failed");
// next-cycle implication
`define SRSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srsw assertion failed");
`else
`define SRSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/srsw_pkg.sv @@
// shared types and constants of the selective-repeat sender window
// no dependencies
`default_nettype none

package srsw_pkg;

    // sizing
    localparam int MAX_PACKETS = 16;
    localparam int MAX_WINDOW  = 8;
    localparam int IDX_W       = $clog2(MAX_PACKETS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WIN_W       = 4;
    localparam int TMR_W       = 8;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // register indexes
    localparam logic [1:0] REG_PACKET_COUNT  = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    // register reset values
    localparam logic [CNT_W-1:0] PC_RESET  = CNT_W'(10);
    localparam logic [WIN_W-1:0] WS_RESET  = WIN_W'(3);
    localparam logic [TMR_W-1:0] TMO_RESET = TMR_W'(5);

    // result kinds
    localparam logic [1:0] KIND_NEW    = 2'd0;
    localparam logic [1:0] KIND_RETX   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_NACK  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_TICK_RD,
        S_TICK_EX,
        S_TICK_NEW,
        S_SLIDE_RD,
        S_SLIDE_EX,
        S_NACK_RD,
        S_NACK_EX,
        S_FLUSH
    } state_t;

    // effective (saturated) configuration
    typedef struct packed {
        logic [CNT_W-1:0] pc;
        logic [WIN_W-1:0] ws;
        logic [TMR_W-1:0] tmo;
    } cfg_eff_t;

    // one access to both state memories
    typedef struct packed {
        logic [IDX_W-1:0] addr;
        logic             re;
        logic             ack_we;
        logic             ack_wdata;
        logic             tmr_we;
        logic [TMR_W-1:0] tmr_wdata;
    } mem_req_t;

    // one result item
    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] send_id;
        logic [CNT_W-1:0] window_base;
        logic             all_done;
        logic             ignored;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/srsw_ram.sv @@
// generic single-port synchronous RAM, registered read data
// no dependencies
`default_nettype none

module srsw_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/srsw_cfg.sv @@
// APB configuration registers and their saturated values
// depends on srsw_pkg
`default_nettype none

module srsw_cfg
    import srsw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              running,
    output cfg_eff_t               cfg
);

    logic [CNT_W-1:0] pc_reg, pc_next;
    logic [WIN_W-1:0] ws_reg, ws_next;
    logic [TMR_W-1:0] tmo_reg, tmo_next;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    // writes are dropped while a transfer is in flight
    assign wr_en   = psel && penable && pwrite && !running;

    // register write decode
    always_comb
    begin
        pc_next  = pc_reg;
        ws_next  = ws_reg;
        tmo_next = tmo_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_PACKET_COUNT:  pc_next  = pwdata[CNT_W-1:0];
                REG_WINDOW_SIZE:   ws_next  = pwdata[WIN_W-1:0];
                REG_TIMEOUT_TICKS: tmo_next = pwdata[TMR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_RESET;
            ws_reg  <= WS_RESET;
            tmo_reg <= TMO_RESET;
        end
        else
        begin
            pc_reg  <= pc_next;
            ws_reg  <= ws_next;
            tmo_reg <= tmo_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_PACKET_COUNT:  prdata = DATA_W'(pc_reg);
            REG_WINDOW_SIZE:   prdata = DATA_W'(ws_reg);
            REG_TIMEOUT_TICKS: prdata = DATA_W'(tmo_reg);
            default:           prdata = '0;
        endcase
    end

    // saturate into the usable ranges
    always_comb
    begin
        if (pc_reg == '0)
        begin
            cfg.pc = CNT_W'(1);
        end
        else if (pc_reg > CNT_W'(MAX_PACKETS))
        begin
            cfg.pc = CNT_W'(MAX_PACKETS);
        end
        else
        begin
            cfg.pc = pc_reg;
        end

        if (ws_reg == '0)
        begin
            cfg.ws = WIN_W'(1);
        end
        else if (ws_reg > WIN_W'(MAX_WINDOW))
        begin
            cfg.ws = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg.ws = ws_reg;
        end

        cfg.tmo = (tmo_reg == '0) ? TMR_W'(1) : tmo_reg;
    end

endmodule

`default_nettype wire

@@ rtl/srsw_core.sv @@
// window sequencer: walks the ack and timer memories and forms results
// depends on srsw_pkg and the assertion macro header
`default_nettype none
`include "selective_repeat_sender_window_top_defines.svh"

module srsw_core
    import srsw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       cmd,
    input  wire logic [CNT_W-1:0] packet_id,
    input  cfg_eff_t              cfg,
    output logic                  running,
    input  wire logic             out_free,
    output logic                  push,
    output result_t               push_data,
    output mem_req_t              mem_req,
    input  wire logic             acked_rdata,
    input  wire logic [TMR_W-1:0] tmr_rdata
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] next_reg, next_next;
    logic             started_reg, started_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             ign_reg, ign_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [1:0]       hold_kind_reg, hold_kind_next;
    logic [CNT_W-1:0] hold_id_reg, hold_id_next;

    cmd_t             cmd_c;
    logic             accept;
    logic             done;
    logic [CNT_W-1:0] pid_m1;
    logic             pid_bad;
    logic [CNT_W-1:0] ws_ext;
    logic [CNT_W-1:0] win_last;
    logic [CNT_W-1:0] pc_m1;
    logic [CNT_W-1:0] end_ext;
    logic [CNT_W-1:0] end_plus1;
    logic [CNT_W-1:0] idx_plus1;
    logic             emit_ok;
    logic             sweep_emit;
    logic             tick_emit;
    logic             new_emit;
    logic             emit;
    logic [1:0]       emit_kind;
    logic [CNT_W-1:0] emit_id;

    // command decode and window arithmetic
    assign cmd_c     = cmd_t'(cmd);
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign done      = started_reg && (base_reg >= cfg.pc);
    assign running   = started_reg && !done;
    assign pid_m1    = packet_id - CNT_W'(1);
    assign pid_bad   = !running || (packet_id == '0) || (packet_id > cfg.pc) ||
                       (pid_m1 >= next_reg);
    assign ws_ext    = CNT_W'(cfg.ws);
    assign win_last  = ((ws_ext < cfg.pc) ? ws_ext : cfg.pc) - CNT_W'(1);
    assign pc_m1     = cfg.pc - CNT_W'(1);
    assign end_ext   = {1'b0, end_reg};
    assign end_plus1 = end_ext + CNT_W'(1);
    assign idx_plus1 = idx_reg + CNT_W'(1);
    // a new result may enter the holding slot when it is empty or can drain
    assign emit_ok    = !hold_valid_reg || out_free;
    assign sweep_emit = (idx_reg <= end_ext);
    assign tick_emit  = !acked_rdata && (tmr_rdata <= TMR_W'(1));
    assign new_emit   = (next_reg < cfg.pc) && (next_reg <= end_ext);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_c)
                        CMD_START: state_next = running ? S_FLUSH : S_SWEEP;
                        CMD_TICK:
                        begin
                            if (!running)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                state_next = (base_reg < next_reg) ? S_TICK_RD : S_TICK_NEW;
                            end
                        end
                        CMD_ACK:
                        begin
                            state_next = (!pid_bad && (base_reg == pid_m1)) ?
                                         S_SLIDE_RD : S_FLUSH;
                        end
                        CMD_NACK:  state_next = pid_bad ? S_FLUSH : S_NACK_RD;
                        default:   state_next = S_FLUSH;
                    endcase
                end
            end
            S_SWEEP:
            begin
                if ((!sweep_emit || emit_ok) &&
                    (idx_reg[IDX_W-1:0] == IDX_W'(MAX_PACKETS - 1)))
                begin
                    state_next = S_FLUSH;
                end
            end
            S_TICK_RD:  state_next = S_TICK_EX;
            S_TICK_EX:
            begin
                if (!tick_emit || emit_ok)
                begin
                    state_next = (idx_plus1 < next_reg) ? S_TICK_RD : S_TICK_NEW;
                end
            end
            S_TICK_NEW:
            begin
                if (!new_emit || emit_ok)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_SLIDE_RD: state_next = (base_reg < cfg.pc) ? S_SLIDE_EX : S_FLUSH;
            S_SLIDE_EX: state_next = acked_rdata ? S_SLIDE_RD : S_FLUSH;
            S_NACK_RD:  state_next = S_NACK_EX;
            S_NACK_EX:  state_next = S_FLUSH;
            S_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath, memory accesses and results
    always_comb
    begin
        base_next       = base_reg;
        end_next        = end_reg;
        next_next       = next_reg;
        started_next    = started_reg;
        idx_next        = idx_reg;
        ign_next        = ign_reg;
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_id_next    = hold_id_reg;
        mem_req         = '0;
        mem_req.addr    = idx_reg[IDX_W-1:0];
        emit            = 1'b0;
        emit_kind       = KIND_NEW;
        emit_id         = idx_plus1;
        push            = 1'b0;
        push_data.kind        = hold_kind_reg;
        push_data.send_id     = hold_id_reg;
        push_data.window_base = base_reg;
        push_data.all_done    = done;
        push_data.ignored     = 1'b0;
        push_data.last        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ign_next = 1'b0;
                    case (cmd_c)
                        CMD_START:
                        begin
                            if (running)
                            begin
                                ign_next = 1'b1;
                            end
                            else
                            begin
                                started_next = 1'b1;
                                base_next    = '0;
                                next_next    = '0;
                                end_next     = win_last[IDX_W-1:0];
                                idx_next     = '0;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (!running)
                            begin
                                ign_next = 1'b1;
                            end
                            else
                            begin
                                idx_next = base_reg;
                            end
                        end
                        CMD_ACK:
                        begin
                            if (pid_bad)
                            begin
                                ign_next = 1'b1;
                            end
                            else
                            begin
                                mem_req.addr      = pid_m1[IDX_W-1:0];
                                mem_req.ack_we    = 1'b1;
                                mem_req.ack_wdata = 1'b1;
                            end
                        end
                        CMD_NACK:
                        begin
                            if (pid_bad)
                            begin
                                ign_next = 1'b1;
                            end
                            else
                            begin
                                idx_next = pid_m1;
                            end
                        end
                        default: ign_next = 1'b1;
                    endcase
                end
            end
            // clear every entry, load timers and send the first window
            S_SWEEP:
            begin
                if (!sweep_emit || emit_ok)
                begin
                    mem_req.ack_we    = 1'b1;
                    mem_req.ack_wdata = 1'b0;
                    mem_req.tmr_we    = 1'b1;
                    mem_req.tmr_wdata = sweep_emit ? cfg.tmo : '0;
                    if (sweep_emit)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_NEW;
                        next_next = idx_plus1;
                    end
                    idx_next = idx_plus1;
                end
            end
            S_TICK_RD:
            begin
                mem_req.re = 1'b1;
            end
            // count down one outstanding timer, resend on expiry
            S_TICK_EX:
            begin
                if (!tick_emit || emit_ok)
                begin
                    if (!acked_rdata)
                    begin
                        mem_req.tmr_we = 1'b1;
                        if (tick_emit)
                        begin
                            mem_req.tmr_wdata = cfg.tmo;
                            emit      = 1'b1;
                            emit_kind = KIND_RETX;
                        end
                        else
                        begin
                            mem_req.tmr_wdata = tmr_rdata - TMR_W'(1);
                        end
                    end
                    idx_next = idx_plus1;
                end
            end
            // one new packet if it lies inside the window
            S_TICK_NEW:
            begin
                if (new_emit && emit_ok)
                begin
                    mem_req.addr      = next_reg[IDX_W-1:0];
                    mem_req.tmr_we    = 1'b1;
                    mem_req.tmr_wdata = cfg.tmo;
                    emit      = 1'b1;
                    emit_kind = KIND_NEW;
                    emit_id   = next_reg + CNT_W'(1);
                    next_next = next_reg + CNT_W'(1);
                end
            end
            S_SLIDE_RD:
            begin
                mem_req.addr = base_reg[IDX_W-1:0];
                mem_req.re   = (base_reg < cfg.pc);
            end
            // slide the base over acknowledged packets
            S_SLIDE_EX:
            begin
                if (acked_rdata)
                begin
                    base_next = base_reg + CNT_W'(1);
                    if (end_ext < pc_m1)
                    begin
                        end_next = end_reg + IDX_W'(1);
                    end
                end
            end
            S_NACK_RD:
            begin
                mem_req.re = 1'b1;
            end
            S_NACK_EX:
            begin
                if (acked_rdata || (idx_reg < base_reg))
                begin
                    ign_next = 1'b1;
                end
                else
                begin
                    mem_req.tmr_we    = 1'b1;
                    mem_req.tmr_wdata = cfg.tmo;
                    emit      = 1'b1;
                    emit_kind = KIND_RETX;
                end
            end
            // final result of this item
            S_FLUSH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_data.last  = 1'b1;
                    hold_valid_next = 1'b0;
                    if (!hold_valid_reg)
                    begin
                        push_data.kind    = KIND_STATUS;
                        push_data.send_id = '0;
                        push_data.ignored = ign_reg;
                    end
                end
            end
            default: ;
        endcase

        // a new result displaces the held one toward the output register
        if (emit)
        begin
            if (hold_valid_reg)
            begin
                push = 1'b1;
            end
            hold_valid_next = 1'b1;
            hold_kind_next  = emit_kind;
            hold_id_next    = emit_id;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= '0;
            end_reg        <= '0;
            next_reg       <= '0;
            started_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            end_reg        <= end_next;
            next_reg       <= next_next;
            started_reg    <= started_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        ign_reg       <= ign_next;
        hold_kind_reg <= hold_kind_next;
        hold_id_reg   <= hold_id_next;
    end

    // checks
    `SRSW_ASSERT_IMP(a_push_has_room, clk, rst_n, push, out_free)
    `SRSW_ASSERT_IMP(a_base_within_sent, clk, rst_n, started_reg, base_reg <= next_reg)
    `SRSW_ASSERT_IMP(a_idle_hold_empty, clk, rst_n, state_reg == S_IDLE, !hold_valid_reg)
    `SRSW_ASSERT_IMP(a_next_within_window, clk, rst_n,
        started_reg && (state_reg == S_IDLE), next_reg <= end_plus1)
    `SRSW_ASSERT_NXT(a_last_ends_item, clk, rst_n, push && push_data.last,
        state_reg == S_IDLE)

endmodule

`default_nettype wire

@@ rtl/selective_repeat_sender_window_top.sv @@
// selective-repeat ARQ sender window: top level with output register
// depends on srsw_pkg, srsw_cfg, srsw_ram and srsw_core
//
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// config   | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
// input    | in_valid, in_stall        | cmd, packet_id
// output   | out_valid, out_stall      | kind, send_id, window_base, all_done,
//          |                           | ignored, last
//
// one item at a time; the sequencer walks the ack and timer memories through
// single-port RAM accesses on a shared address (read, then write back where needed)
// start: a sweep of all MAX_PACKETS entries that clears marks and sends the window
// tick: each sent packet from the base, acknowledged or not, then one new packet
// ack: marks the entry, and at the window base slides the base over acked entries
// nack resends an unacked entry; an output stall holds any item in progress
// reset needs no memory pass: start clears the state memories itself
`default_nettype none

module selective_repeat_sender_window_top
    import srsw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        cmd,
    input  wire logic [CNT_W-1:0]  packet_id,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [1:0]        kind,
    output logic      [CNT_W-1:0]  send_id,
    output logic      [CNT_W-1:0]  window_base,
    output logic                   all_done,
    output logic                   ignored,
    output logic                   last
);

    cfg_eff_t         cfg;
    logic             running;
    logic             out_free;
    logic             push;
    result_t          push_data;
    mem_req_t         mem_req;
    logic             acked_rdata;
    logic [TMR_W-1:0] tmr_rdata;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg;

    srsw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .running (running),
        .cfg     (cfg)
    );

    srsw_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .packet_id   (packet_id),
        .cfg         (cfg),
        .running     (running),
        .out_free    (out_free),
        .push        (push),
        .push_data   (push_data),
        .mem_req     (mem_req),
        .acked_rdata (acked_rdata),
        .tmr_rdata   (tmr_rdata)
    );

    // acknowledgement marks
    srsw_ram #(
        .DEPTH (MAX_PACKETS),
        .WIDTH (1)
    ) u_ack_ram (
        .clk   (clk),
        .addr  (mem_req.addr),
        .we    (mem_req.ack_we),
        .wdata (mem_req.ack_wdata),
        .re    (mem_req.re),
        .rdata (acked_rdata)
    );

    // retry timers
    srsw_ram #(
        .DEPTH (MAX_PACKETS),
        .WIDTH (TMR_W)
    ) u_tmr_ram (
        .clk   (clk),
        .addr  (mem_req.addr),
        .we    (mem_req.tmr_we),
        .wdata (mem_req.tmr_wdata),
        .re    (mem_req.re),
        .rdata (tmr_rdata)
    );

    // output register, free when empty or draining this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg <= push_data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_data_reg.kind;
    assign send_id     = out_data_reg.send_id;
    assign window_base = out_data_reg.window_base;
    assign all_done    = out_data_reg.all_done;
    assign ignored     = out_data_reg.ignored;
    assign last        = out_data_reg.last;

endmodule

`default_nettype wire
